FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");
// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`else
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: src/rinv_pkg.sv
// ----------------------------------------------------------------------------
// rinv_pkg
// Shared types and constants of the radical inverse unit.
// ----------------------------------------------------------------------------
package rinv_pkg;

  // Width of one digit and of one division chunk
  localparam int DIGIT_W = 8;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_ACC  = 5'b00100,
    S_FRAC = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

endpackage

FILE: src/radical_inverse_unit.sv
// ----------------------------------------------------------------------------
// radical_inverse_unit
// Halton radical inverse of a sample index in a given base, as a
// truncated unsigned fixed-point fraction.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low;
//   sample_index and digit_base are sampled there. busy stays high until
//   the result has been shown. The result appears on fraction for exactly
//   one cycle with done high; the receiver cannot stall it.
// Operation:
//   the index is split into C = ceil(INDEX_BITS/8) chunks. For each digit
//   of the index in the base, one shared 8-bit chunk divider works through
//   the chunks, then a multiply-accumulate step appends the digit; the
//   final quotient is then formed one bit per cycle by a restoring divider.
//   Index zero or base below two goes straight to done. One item is in
//   work at a time, and the next request is taken at the earliest in the
//   cycle after done.
// Reset: synchronous, active high; returns to idle, drops any request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module radical_inverse_unit #(
  parameter int INDEX_BITS    = 32,
  parameter int FRACTION_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [INDEX_BITS-1:0]    sample_index,
  input  logic [rinv_pkg::DIGIT_W-1:0] digit_base,
  output logic                     busy,
  output logic                     done,
  output logic [FRACTION_BITS-1:0] fraction
);
  import rinv_pkg::*;

  localparam int CHUNKS = (INDEX_BITS + DIGIT_W - 1) / DIGIT_W;
  localparam int PADW   = CHUNKS * DIGIT_W;
  localparam int DW     = INDEX_BITS + DIGIT_W;
  localparam int CW     = $clog2(CHUNKS + 1);
  localparam int FCW    = $clog2(FRACTION_BITS + 1);

  state_t               state, state_next;
  logic [PADW-1:0]      work;
  logic [DIGIT_W-1:0]   rem;
  logic [DIGIT_W-1:0]   base;
  logic [DW-1:0]        num;
  logic [DW-1:0]        den;
  logic [FRACTION_BITS-1:0] q;
  logic [CW-1:0]        chunk_cnt;
  logic [FCW-1:0]       bit_cnt;

  logic [DIGIT_W-1:0]   step_quo;
  logic [DIGIT_W-1:0]   step_rem;
  logic [DW+DIGIT_W-1:0] num_prod;
  logic [DW+DIGIT_W-1:0] den_prod;
  logic [DW:0]          rem_sh;
  logic                 rem_ge;
  logic                 accept;
  logic                 trivial;

  assign accept  = start && !busy;
  assign trivial = (digit_base < DIGIT_W'(2)) || (sample_index == '0);
  assign busy    = (state != S_IDLE);
  assign done    = (state == S_DONE);
  assign fraction = q;

  // Shared chunk divider: top chunk of the working index against the base
  rinv_divstep u_divstep (
    .rem_in  (rem),
    .chunk   (work[PADW-1 -: DIGIT_W]),
    .base    (base),
    .quo     (step_quo),
    .rem_out (step_rem)
  );

  // Digit accumulate products
  assign num_prod = {{DIGIT_W{1'b0}}, num} * {{DW{1'b0}}, base};
  assign den_prod = {{DIGIT_W{1'b0}}, den} * {{DW{1'b0}}, base};

  // Final quotient step
  assign rem_sh = {num, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, den});

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = trivial ? S_DONE : S_DIV;
      S_DIV:  if (chunk_cnt == CW'(CHUNKS - 1)) state_next = S_ACC;
      S_ACC:  state_next = (work == '0) ? S_FRAC : S_DIV;
      S_FRAC: if (bit_cnt == FCW'(FRACTION_BITS - 1)) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        work      <= PADW'(sample_index);
        base      <= digit_base;
        rem       <= '0;
        num       <= '0;
        den       <= DW'(1);
        q         <= '0;
        chunk_cnt <= '0;
        bit_cnt   <= '0;
      end
      S_DIV: begin
        // shift out the top chunk, shift in its quotient bits
        work      <= (work << DIGIT_W) | PADW'(step_quo);
        rem       <= step_rem;
        chunk_cnt <= chunk_cnt + CW'(1);
      end
      S_ACC: begin
        // append the digit, grow the denominator, restart the divider
        num       <= num_prod[DW-1:0] + DW'(rem);
        den       <= den_prod[DW-1:0];
        rem       <= '0;
        chunk_cnt <= '0;
      end
      S_FRAC: begin
        num     <= rem_ge ? DW'(rem_sh - {1'b0, den}) : DW'(rem_sh);
        q       <= {q[FRACTION_BITS-2:0], rem_ge};
        bit_cnt <= bit_cnt + FCW'(1);
      end
      S_DONE: begin
        bit_cnt <= '0;
      end
      default: begin
        bit_cnt <= '0;
      end
    endcase
  end

  `ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `ASSERT_NEXT(a_done_frees, clk, rst, done, !busy && !done)
  `ASSERT_SAME(a_den_nonzero, clk, rst, state == S_FRAC, den != '0)
  `ASSERT_SAME(a_rem_below_den, clk, rst, state == S_FRAC, num < den)

endmodule

FILE: src/rinv_divstep.sv
// ----------------------------------------------------------------------------
// rinv_divstep
// Divide one 8-bit chunk (with incoming remainder) by the base: eight
// restoring steps, giving eight quotient bits and the new remainder.
// ----------------------------------------------------------------------------
module rinv_divstep (
  input  logic [rinv_pkg::DIGIT_W-1:0] rem_in,
  input  logic [rinv_pkg::DIGIT_W-1:0] chunk,
  input  logic [rinv_pkg::DIGIT_W-1:0] base,
  output logic [rinv_pkg::DIGIT_W-1:0] quo,
  output logic [rinv_pkg::DIGIT_W-1:0] rem_out
);
  import rinv_pkg::*;

  // Restoring division over the chunk bits, MSB first
  always_comb begin
    logic [DIGIT_W:0] r;
    r = {1'b0, rem_in};
    quo = '0;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      r = {r[DIGIT_W-1:0], chunk[i]};
      if (r >= {1'b0, base}) begin
        r = r - {1'b0, base};
        quo[i] = 1'b1;
      end
    end
    rem_out = r[DIGIT_W-1:0];
  end

endmodule
